// File: rtl/i2cbe_pkg.sv
// Shared types and constants for the I2C master bit engine.
package i2cbe_pkg;

  localparam int PHASE_W = 16;
  localparam logic [PHASE_W-1:0] PHASE_CYCLES_RST = 16'd125;
  localparam int FIFO_DEPTH_DEF = 2;

  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_STOP  = 3'd1,
    OP_WRITE = 3'd2,
    OP_READ  = 3'd3,
    OP_RACK  = 3'd4,
    OP_WACK  = 3'd5
  } op_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_RUN  = 1'b1
  } bk_state_t;

  // Classified command handed from front to back
  typedef struct packed {
    op_t        op;
    logic [7:0] data;   // byte to send, or slave SDA levels to sample
    logic       ack;    // level for write ack
  } cmd_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic [7:0] rd;
    logic       ack;
    logic       last;
  } phase_t;

endpackage

// File: rtl/i2cbe_front.sv
// Front end: accepts input transactions, drops undefined commands, stages the rest.
module i2cbe_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [23:0]         in_tdata,
  input  logic [2:0]          in_tuser,
  output logic                push_valid,
  input  logic                push_ready,
  output i2cbe_pkg::cmd_t     push_data
);

  logic            stg_valid_r;
  logic            stg_valid_nxt;
  i2cbe_pkg::cmd_t stg_cmd_r;
  i2cbe_pkg::cmd_t stg_cmd_nxt;
  logic            accept;
  logic            op_ok;
  logic [7:0]      write_data;
  logic            ack_out;
  logic [7:0]      bus_sda_bits;

  assign write_data   = in_tdata[7:0];
  assign ack_out      = in_tdata[8];
  assign bus_sda_bits = in_tdata[16:9];

  assign in_tready = !stg_valid_r || push_ready;
  assign accept    = in_tvalid && in_tready;
  assign op_ok     = in_tuser <= 3'(i2cbe_pkg::OP_WACK);

  always_comb begin
    stg_cmd_nxt.op   = i2cbe_pkg::op_t'(in_tuser);
    stg_cmd_nxt.ack  = ack_out;
    stg_cmd_nxt.data = 8'd0;
    case (i2cbe_pkg::op_t'(in_tuser))
      i2cbe_pkg::OP_WRITE: stg_cmd_nxt.data = write_data;
      i2cbe_pkg::OP_READ:  stg_cmd_nxt.data = bus_sda_bits;
      i2cbe_pkg::OP_RACK:  stg_cmd_nxt.data = bus_sda_bits;
      default:             stg_cmd_nxt.data = 8'd0;
    endcase
  end

  // Drop undefined commands; otherwise hold until the queue takes the entry
  assign stg_valid_nxt = (accept && op_ok) ? 1'b1 :
                         (push_ready ? 1'b0 : stg_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && op_ok) begin
      stg_cmd_r <= stg_cmd_nxt;
    end
  end

  assign push_valid = stg_valid_r;
  assign push_data  = stg_cmd_r;

endmodule

// File: rtl/i2cbe_fifo.sv
// Short command queue between front and back ends.
module i2cbe_fifo #(
  parameter int DEPTH = i2cbe_pkg::FIFO_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  i2cbe_pkg::cmd_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output i2cbe_pkg::cmd_t pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  i2cbe_pkg::cmd_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = count_r != CNT_W'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/i2cbe_back.sv
// Back end: runs one command as a sequence of held SCL/SDA phases.
module i2cbe_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [i2cbe_pkg::PHASE_W-1:0]   cfg_wr_data,
  input  logic                            pop_valid,
  output logic                            pop_ready,
  input  i2cbe_pkg::cmd_t                 pop_data,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [15:0]                     out_tdata,
  output logic                            out_tlast
);

  i2cbe_pkg::bk_state_t state_r, state_nxt;
  i2cbe_pkg::cmd_t      cmd_r;
  i2cbe_pkg::phase_t    ph;
  i2cbe_pkg::phase_t    out_ph_r;
  logic [i2cbe_pkg::PHASE_W-1:0] phase_cycles_r;
  logic [i2cbe_pkg::PHASE_W-1:0] timer_r, timer_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [2:0] bit_r, bit_nxt;
  logic [1:0] sub_r, sub_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       emit;
  logic       load;
  logic       bit_end;

  assign load = pop_valid && pop_ready;
  assign emit = (state_r == i2cbe_pkg::BK_RUN) && (timer_r == '0) &&
                (!out_valid_r || out_tready);

  // Pin levels for the current phase
  always_comb begin
    ph = '0;
    case (cmd_r.op)
      i2cbe_pkg::OP_START: begin
        ph.scl  = sub_r != 2'd2;
        ph.sda  = sub_r == 2'd0;
        ph.last = sub_r == 2'd2;
      end
      i2cbe_pkg::OP_STOP: begin
        ph.scl  = 1'b1;
        ph.sda  = sub_r == 2'd1;
        ph.last = sub_r == 2'd1;
      end
      i2cbe_pkg::OP_WRITE: begin
        ph.scl  = sub_r == 2'd1;
        ph.sda  = shift_r[7];
        ph.last = (bit_r == 3'd7) && (sub_r == 2'd2);
      end
      i2cbe_pkg::OP_READ: begin
        ph.scl  = sub_r == 2'd0;
        ph.sda  = 1'b1;
        ph.last = (bit_r == 3'd7) && (sub_r == 2'd1);
        ph.rd   = ph.last ? shift_r : 8'd0;
      end
      i2cbe_pkg::OP_RACK: begin
        ph.scl  = sub_r == 2'd0;
        ph.sda  = 1'b1;
        ph.last = sub_r == 2'd1;
        ph.ack  = ph.last && cmd_r.data[0];
      end
      i2cbe_pkg::OP_WACK: begin
        ph.scl  = sub_r == 2'd0;
        ph.sda  = cmd_r.ack;
        ph.last = sub_r == 2'd1;
      end
      default: ph.last = 1'b1;
    endcase
  end

  assign bit_end = ((cmd_r.op == i2cbe_pkg::OP_WRITE) && (sub_r == 2'd2)) ||
                   ((cmd_r.op == i2cbe_pkg::OP_READ) && (sub_r == 2'd1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      i2cbe_pkg::BK_IDLE: if (pop_valid) state_nxt = i2cbe_pkg::BK_RUN;
      i2cbe_pkg::BK_RUN:  if (emit && ph.last) state_nxt = i2cbe_pkg::BK_IDLE;
      default:            state_nxt = i2cbe_pkg::BK_IDLE;
    endcase
  end

  // Outputs of the state machine
  always_comb begin
    case (state_r)
      i2cbe_pkg::BK_IDLE: pop_ready = 1'b1;
      default:            pop_ready = 1'b0;
    endcase
  end

  // Bit/phase counters and the shift register
  always_comb begin
    bit_nxt   = bit_r;
    sub_nxt   = sub_r;
    shift_nxt = shift_r;
    if (load) begin
      bit_nxt   = 3'd0;
      sub_nxt   = 2'd0;
      shift_nxt = pop_data.data;
    end else if (emit) begin
      if (bit_end) begin
        sub_nxt = 2'd0;
        bit_nxt = bit_r + 3'd1;
      end else begin
        sub_nxt = sub_r + 2'd1;
      end
      // Write: advance to the next bit after SCL falls.
      // Read: sample on SCL high; after eight samples the register holds the byte.
      if ((cmd_r.op == i2cbe_pkg::OP_WRITE) && (sub_r == 2'd2)) begin
        shift_nxt = {shift_r[6:0], 1'b0};
      end else if ((cmd_r.op == i2cbe_pkg::OP_READ) && (sub_r == 2'd0)) begin
        shift_nxt = {shift_r[6:0], shift_r[7]};
      end
    end
  end

  always_comb begin
    timer_nxt = timer_r;
    if (emit) begin
      timer_nxt = (phase_cycles_r == '0) ? '0 : phase_cycles_r - 16'd1;
    end else if (timer_r != '0) begin
      timer_nxt = timer_r - 16'd1;
    end
  end

  assign out_valid_nxt = emit ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= i2cbe_pkg::BK_IDLE;
      timer_r        <= '0;
      out_valid_r    <= 1'b0;
      phase_cycles_r <= i2cbe_pkg::PHASE_CYCLES_RST;
      shift_r        <= 8'd0;
      bit_r          <= 3'd0;
      sub_r          <= 2'd0;
    end else begin
      state_r     <= state_nxt;
      timer_r     <= timer_nxt;
      out_valid_r <= out_valid_nxt;
      shift_r     <= shift_nxt;
      bit_r       <= bit_nxt;
      sub_r       <= sub_nxt;
      if (cfg_wr_en) begin
        phase_cycles_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd_r <= pop_data;
    end
    if (emit) begin
      out_ph_r <= ph;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_ph_r.ack, out_ph_r.rd, out_ph_r.sda, out_ph_r.scl};
  assign out_tlast  = out_ph_r.last;

endmodule

// File: rtl/i2c_master_bit_engine.sv
// Top level of the I2C master bit engine.
// Usage:
//   Input channel (in_*): one bus command per transaction; in_tuser carries the
//   command code (start, stop, write byte, read byte, read ack, write ack),
//   in_tdata the byte to send, the ack level and the slave's SDA levels.
//   Undefined codes are accepted and dropped without any output.
//   Output channel (out_*): one transaction per pin phase, carrying SCL and SDA
//   levels, the read byte and sampled ack; out_tlast marks a command's final phase.
//   cfg_wr_en/cfg_wr_data set how many cycles each phase is held (0 acts as 1);
//   write it only while no command is in flight.
// Flow:
//   An accepted command passes the staging register, the queue, the back end's
//   command register and the phase register before its first phase goes out,
//   once the back end is idle and its hold timer has expired. The back end starts
//   a command only after the last phase of the previous one; a command has 2 to
//   24 phases. Front end and FIFO_DEPTH-entry queue keep accepting meanwhile.
// Reset (rst_n low, synchronous): queue and sequencer empty, out_tvalid low,
//   phase_cycles back to PHASE_CYCLES_RST.
// Stall: while out_tready is low the current phase is held on out_tdata and the
//   sequencer waits; phases are never dropped or repeated.
module i2c_master_bit_engine #(
  parameter int FIFO_DEPTH = i2cbe_pkg::FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,   // phase_cycles
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,      // write_data[7:0], ack_out[8], bus_sda_bits[16:9]
  input  logic [2:0]  in_tuser,      // op[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,     // scl_level[0], sda_level[1], read_data[9:2], ack_in[10]
  output logic        out_tlast      // last_phase
);

  logic            push_valid, push_ready;
  logic            pop_valid, pop_ready;
  i2cbe_pkg::cmd_t push_data, pop_data;

  i2cbe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  i2cbe_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  i2cbe_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_data    (pop_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule

// File: rtl/i2cbe_checker.sv
// Port-level checks for the I2C master bit engine, bound to the top level.
module i2cbe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  // Hold a stalled transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output transaction dropped while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // Read byte and ack fields carry data only on a command's final phase
  a_result_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[10:2] == 9'd0)
    else $error("read result outside final phase");

  // Only stop ends with SCL high, and it ends with SDA released
  a_stop_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast && out_tdata[0] |-> out_tdata[1] && out_tdata[15:11] == 5'd0)
    else $error("final phase with SCL high but SDA low");

endmodule

bind i2c_master_bit_engine i2cbe_checker u_i2cbe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
